// ===== hw/rtl/omni_wheel_drive_mixer_defines.svh =====
// assertion macros for the omni wheel drive mixer
// used by omni_wheel_drive_mixer.sv, no other dependencies
`ifndef OMNI_WHEEL_DRIVE_MIXER_DEFINES_SVH
`define OMNI_WHEEL_DRIVE_MIXER_DEFINES_SVH
`ifndef SYNTHESIS
`define OWDM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define OWDM_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("assertion failed");
`else
`define OWDM_ASSERT(lbl, clk, rst, prop)
`define OWDM_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/owdm_pkg.sv =====
// constants, types and the quarter sine table of the omni wheel drive mixer
// no dependencies
`default_nettype none
package owdm_pkg;
   localparam int FRACTION_BITS = 14;
   localparam int DUTY_MAX = 255;
   localparam int DUTY_W = 8;
   localparam int WHEELS = 4;
   localparam int FAC_W = FRACTION_BITS + 2;
   localparam int MAG_W = FRACTION_BITS + 1;
   localparam int QUO_W = FRACTION_BITS + 2;
   localparam int NUM_W = MAG_W + FRACTION_BITS;
   localparam int SC_W = QUO_W + 1;
   localparam int PROD_W = SC_W + 9;
   localparam int P_W = PROD_W + 1;
   localparam int IDX_W = 7;
   localparam int ANG_W = 9;

   localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(DUTY_MAX);

   localparam logic [1:0] OP_RUN = 2'd0;
   localparam logic [1:0] OP_BRAKE = 2'd1;
   localparam logic [1:0] OP_COAST = 2'd2;

   localparam logic [1:0] CSR_DRIVE_SPEED = 2'd0;
   localparam logic [1:0] CSR_CORRECTION_POWER = 2'd1;
   localparam logic [1:0] CSR_DEADBAND_LOW = 2'd2;
   localparam logic [1:0] CSR_DEADBAND_HIGH = 2'd3;

   localparam logic [ANG_W-1:0] MOUNT_DEG [WHEELS] = '{9'd40, 9'd140, 9'd225, 9'd315};

   typedef logic [MAG_W-1:0] qsin_table_type [0:90];
   typedef logic signed [FAC_W-1:0] factor_type;

   typedef struct packed {
      logic [1:0] op;
      logic scale;
      logic signed [8:0] add;
      factor_type [WHEELS-1:0] fac;
   } side_type;

   function automatic longint round_q30(longint v);
      longint r;
      if (v >= 0) begin
         r = (v + (longint'(1) << 29)) >>> 30;
      end else begin
         r = -((-v + (longint'(1) << 29)) >>> 30);
      end
      return r;
   endfunction

   // 1 degree rotation recurrence in q30, rounded to the fraction width
   function automatic qsin_table_type build_qsin_table();
      qsin_table_type t;
      longint c;
      longint s;
      longint nc;
      longint ns;
      longint r;
      longint sp;
      c = longint'(1) << 30;
      s = 0;
      for (int k = 0; k <= 90; k++) begin
         sp = (s < 0) ? 0 : s;
         r = (sp + (longint'(1) << (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
         if (r > (longint'(1) << FRACTION_BITS)) begin
            r = longint'(1) << FRACTION_BITS;
         end
         t[k] = r[MAG_W-1:0];
         nc = round_q30(c * 64'sd1073578288 - s * 64'sd18739379);
         ns = round_q30(s * 64'sd1073578288 + c * 64'sd18739379);
         c = nc;
         s = ns;
      end
      return t;
   endfunction

   localparam qsin_table_type QSIN_TABLE = build_qsin_table();
endpackage
`default_nettype wire

// ===== hw/rtl/omni_wheel_drive_mixer.sv =====
// top level of the omni wheel drive mixer: angle fold, sine lookup, scaling, duty output
// depends on owdm_pkg, owdm_div and omni_wheel_drive_mixer_defines.svh
`default_nettype none
`include "omni_wheel_drive_mixer_defines.svh"
// A command is taken in every cycle that start is high (busy stays low); its
// eight bridge duties pass the fold, lookup, operand, divider, product and output
// stages and appear with rsp_valid for one cycle. The normalizing divider
// resolves one quotient bit per pipeline stage; throughput is one command per
// cycle. The receiver cannot stall the output. The user must write registers through
// the csr port only while no command is in flight; the block does not enforce this.
module omni_wheel_drive_mixer (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic [1:0] req_operation,
   input  wire logic [8:0] req_heading_angle,
   input  wire logic [8:0] req_gyro_heading,
   input  wire logic csr_write_enable,
   input  wire logic [1:0] csr_index,
   input  wire logic [8:0] csr_write_data,
   output logic rsp_valid,
   output logic [7:0] rsp_wheel0_pin_a_duty,
   output logic [7:0] rsp_wheel0_pin_b_duty,
   output logic [7:0] rsp_wheel1_pin_a_duty,
   output logic [7:0] rsp_wheel1_pin_b_duty,
   output logic [7:0] rsp_wheel2_pin_a_duty,
   output logic [7:0] rsp_wheel2_pin_b_duty,
   output logic [7:0] rsp_wheel3_pin_a_duty,
   output logic [7:0] rsp_wheel3_pin_b_duty
);
   localparam int W = owdm_pkg::WHEELS;
   localparam int Q = owdm_pkg::QUO_W;
   localparam int FB = owdm_pkg::FRACTION_BITS;
   localparam int LATENCY = Q + 5;
   localparam logic signed [owdm_pkg::FAC_W-1:0] ONE = owdm_pkg::FAC_W'(1 << FB);

   // configuration
   logic [7:0] speed_ff;
   logic [7:0] corr_ff;
   logic [8:0] dlow_ff;
   logic [8:0] dhigh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= 8'd0;
         corr_ff <= 8'd20;
         dlow_ff <= 9'd10;
         dhigh_ff <= 9'd350;
      end else if (csr_write_enable) begin
         case (csr_index)
            owdm_pkg::CSR_DRIVE_SPEED: speed_ff <= csr_write_data[7:0];
            owdm_pkg::CSR_CORRECTION_POWER: corr_ff <= csr_write_data[7:0];
            owdm_pkg::CSR_DEADBAND_LOW: dlow_ff <= csr_write_data;
            owdm_pkg::CSR_DEADBAND_HIGH: dhigh_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // stage 1: angle fold and correction select
   logic v1_ff;
   logic [1:0] op1_ff;
   logic signed [8:0] add1_ff;
   logic [owdm_pkg::IDX_W-1:0] idx1_ff [W];
   logic neg1_ff [W];

   logic [owdm_pkg::IDX_W-1:0] idx1_in [W];
   logic neg1_in [W];
   logic signed [8:0] add1_in;

   always_comb begin
      logic signed [11:0] a;
      logic signed [11:0] x;
      logic [8:0] d;
      a = 12'sd450 - $signed({3'b000, req_heading_angle});
      if (a > 12'sd360) begin
         a = a - 12'sd360;
      end
      for (int w = 0; w < W; w++) begin
         x = a - $signed({3'b000, owdm_pkg::MOUNT_DEG[w]});
         if (x < -12'sd360) begin
            x = x + 12'sd720;
         end else if (x < 12'sd0) begin
            x = x + 12'sd360;
         end else if (x >= 12'sd360) begin
            x = x - 12'sd360;
         end
         d = x[8:0];
         if (d <= 9'd90) begin
            idx1_in[w] = d[owdm_pkg::IDX_W-1:0];
            neg1_in[w] = 1'b0;
         end else if (d <= 9'd180) begin
            idx1_in[w] = owdm_pkg::IDX_W'(9'd180 - d);
            neg1_in[w] = 1'b0;
         end else if (d <= 9'd270) begin
            idx1_in[w] = owdm_pkg::IDX_W'(d - 9'd180);
            neg1_in[w] = 1'b1;
         end else begin
            idx1_in[w] = owdm_pkg::IDX_W'(9'd360 - d);
            neg1_in[w] = 1'b1;
         end
      end
      if (req_gyro_heading >= dlow_ff && req_gyro_heading < 9'd180) begin
         add1_in = -$signed({1'b0, corr_ff});
      end else if (req_gyro_heading < dhigh_ff && req_gyro_heading >= 9'd180) begin
         add1_in = $signed({1'b0, corr_ff});
      end else begin
         add1_in = 9'sd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
      op1_ff <= req_operation;
      add1_ff <= add1_in;
      idx1_ff <= idx1_in;
      neg1_ff <= neg1_in;
   end

   // stage 2: sine lookup, factor is minus the sine
   logic v2_ff;
   logic [1:0] op2_ff;
   logic signed [8:0] add2_ff;
   owdm_pkg::factor_type f2_ff [W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      op2_ff <= op1_ff;
      add2_ff <= add1_ff;
      for (int w = 0; w < W; w++) begin
         if (neg1_ff[w]) begin
            f2_ff[w] <= $signed({1'b0, owdm_pkg::QSIN_TABLE[idx1_ff[w]]});
         end else begin
            f2_ff[w] <= -$signed({1'b0, owdm_pkg::QSIN_TABLE[idx1_ff[w]]});
         end
      end
   end

   // stage 3: largest factor and divider operands
   logic v3_ff;
   owdm_pkg::side_type side3_ff;
   logic [owdm_pkg::MAG_W-1:0] mx3_ff;
   logic [owdm_pkg::MAG_W-1:0] mag3_ff [W];

   owdm_pkg::factor_type mx_in;
   logic [owdm_pkg::MAG_W-1:0] mag_in [W];

   always_comb begin
      owdm_pkg::factor_type m01;
      owdm_pkg::factor_type m23;
      m01 = (f2_ff[0] > f2_ff[1]) ? f2_ff[0] : f2_ff[1];
      m23 = (f2_ff[2] > f2_ff[3]) ? f2_ff[2] : f2_ff[3];
      mx_in = (m01 > m23) ? m01 : m23;
      if (mx_in < 0) begin
         mx_in = '0;
      end
      for (int w = 0; w < W; w++) begin
         mag_in[w] = f2_ff[w][owdm_pkg::FAC_W-1] ?
            owdm_pkg::MAG_W'(-f2_ff[w]) : owdm_pkg::MAG_W'(f2_ff[w]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      side3_ff.op <= op2_ff;
      side3_ff.add <= add2_ff;
      side3_ff.scale <= (mx_in > 0) && (mx_in < ONE);
      for (int w = 0; w < W; w++) begin
         side3_ff.fac[w] <= f2_ff[w];
      end
      mx3_ff <= mx_in[owdm_pkg::MAG_W-1:0];
      mag3_ff <= mag_in;
   end

   // normalizing dividers, one per wheel
   logic [Q-1:0] quo [W];

   for (genvar w = 0; w < W; w++) begin : g_div
      owdm_div u_div (
         .clock(clock),
         .num({mag3_ff[w], {FB{1'b0}}}),
         .den(mx3_ff),
         .quo(quo[w])
      );
   end

   logic vd_ff [Q];
   owdm_pkg::side_type sd_ff [Q];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Q; i++) begin
            vd_ff[i] <= 1'b0;
         end
      end else begin
         vd_ff[0] <= v3_ff;
         for (int i = 1; i < Q; i++) begin
            vd_ff[i] <= vd_ff[i-1];
         end
      end
      sd_ff[0] <= side3_ff;
      for (int i = 1; i < Q; i++) begin
         sd_ff[i] <= sd_ff[i-1];
      end
   end

   // product stage
   logic vp_ff;
   logic [1:0] opp_ff;
   logic signed [8:0] addp_ff;
   logic signed [owdm_pkg::PROD_W-1:0] prod_ff [W];

   owdm_pkg::side_type sdq;
   assign sdq = sd_ff[Q-1];

   always_ff @(posedge clock) begin
      logic signed [owdm_pkg::SC_W-1:0] sc;
      logic signed [owdm_pkg::SC_W-1:0] qs;
      if (reset) begin
         vp_ff <= 1'b0;
      end else begin
         vp_ff <= vd_ff[Q-1];
      end
      opp_ff <= sdq.op;
      addp_ff <= sdq.add;
      for (int w = 0; w < W; w++) begin
         qs = $signed({1'b0, quo[w]});
         if (sdq.scale) begin
            sc = sdq.fac[w][owdm_pkg::FAC_W-1] ? -qs : qs;
         end else begin
            sc = owdm_pkg::SC_W'(sdq.fac[w]);
         end
         prod_ff[w] <= $signed({1'b0, speed_ff}) * sc;
      end
   end

   // output stage: correction, truncation and bridge duties
   logic rsp_valid_ff;
   logic [7:0] duty_a_ff [W];
   logic [7:0] duty_b_ff [W];
   logic [7:0] duty_a_in [W];
   logic [7:0] duty_b_in [W];

   always_comb begin
      logic signed [owdm_pkg::P_W-1:0] p;
      logic [owdm_pkg::P_W-1:0] mag;
      logic [7:0] duty;
      for (int w = 0; w < W; w++) begin
         p = owdm_pkg::P_W'(prod_ff[w]) + (owdm_pkg::P_W'(addp_ff) <<< FB);
         mag = p[owdm_pkg::P_W-1] ? owdm_pkg::P_W'(-p) : owdm_pkg::P_W'(p);
         mag = mag >> FB;
         duty = (mag > owdm_pkg::P_W'(owdm_pkg::DUTY_MAX)) ?
            owdm_pkg::DUTY_FULL : mag[7:0];
         case (opp_ff)
            owdm_pkg::OP_RUN: begin
               if (mag == '0) begin
                  duty_a_in[w] = owdm_pkg::DUTY_FULL;
                  duty_b_in[w] = owdm_pkg::DUTY_FULL;
               end else if (p[owdm_pkg::P_W-1]) begin
                  duty_a_in[w] = duty;
                  duty_b_in[w] = 8'd0;
               end else begin
                  duty_a_in[w] = 8'd0;
                  duty_b_in[w] = duty;
               end
            end
            owdm_pkg::OP_BRAKE: begin
               duty_a_in[w] = owdm_pkg::DUTY_FULL;
               duty_b_in[w] = owdm_pkg::DUTY_FULL;
            end
            default: begin
               duty_a_in[w] = 8'd0;
               duty_b_in[w] = 8'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vp_ff;
      end
      duty_a_ff <= duty_a_in;
      duty_b_ff <= duty_b_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_wheel0_pin_a_duty = duty_a_ff[0];
   assign rsp_wheel0_pin_b_duty = duty_b_ff[0];
   assign rsp_wheel1_pin_a_duty = duty_a_ff[1];
   assign rsp_wheel1_pin_b_duty = duty_b_ff[1];
   assign rsp_wheel2_pin_a_duty = duty_a_ff[2];
   assign rsp_wheel2_pin_b_duty = duty_b_ff[2];
   assign rsp_wheel3_pin_a_duty = duty_a_ff[3];
   assign rsp_wheel3_pin_b_duty = duty_b_ff[3];

   `OWDM_ASSERT_IMPL(a_transfer_latency, clock, reset, accept, ##(LATENCY) rsp_valid)
   `OWDM_ASSERT_IMPL(a_no_stray_result, clock, reset, rsp_valid, $past(accept, LATENCY))
   `OWDM_ASSERT_IMPL(a_brake_full, clock, reset, accept && req_operation == owdm_pkg::OP_BRAKE, ##(LATENCY) (rsp_wheel0_pin_a_duty == owdm_pkg::DUTY_FULL && rsp_wheel3_pin_b_duty == owdm_pkg::DUTY_FULL))
   `OWDM_ASSERT_IMPL(a_bridge_one_side, clock, reset, rsp_valid && rsp_wheel0_pin_a_duty != 8'd0 && rsp_wheel0_pin_b_duty != 8'd0, (rsp_wheel0_pin_a_duty == owdm_pkg::DUTY_FULL && rsp_wheel0_pin_b_duty == owdm_pkg::DUTY_FULL))
endmodule
`default_nettype wire

// ===== hw/rtl/owdm_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on owdm_pkg
`default_nettype none
module owdm_div (
   input  wire logic clock,
   input  wire logic [owdm_pkg::NUM_W-1:0] num,
   input  wire logic [owdm_pkg::MAG_W-1:0] den,
   output logic [owdm_pkg::QUO_W-1:0] quo
);
   localparam int CMP_W = owdm_pkg::MAG_W + owdm_pkg::QUO_W;

   logic [owdm_pkg::NUM_W-1:0] rem_ff [owdm_pkg::QUO_W];
   logic [owdm_pkg::MAG_W-1:0] den_ff [owdm_pkg::QUO_W];
   logic [owdm_pkg::QUO_W-1:0] quo_ff [owdm_pkg::QUO_W];

   for (genvar s = 0; s < owdm_pkg::QUO_W; s++) begin : g_stage
      localparam int B = owdm_pkg::QUO_W - 1 - s;
      logic [owdm_pkg::NUM_W-1:0] rem_prev;
      logic [owdm_pkg::MAG_W-1:0] den_prev;
      logic [owdm_pkg::QUO_W-1:0] quo_prev;
      logic [CMP_W-1:0] trial;
      logic [CMP_W-1:0] rem_ext;
      logic [owdm_pkg::NUM_W-1:0] rem_in;
      logic [owdm_pkg::QUO_W-1:0] quo_in;

      if (s == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign den_prev = den_ff[s-1];
         assign quo_prev = quo_ff[s-1];
      end

      always_comb begin
         trial = CMP_W'(den_prev) << B;
         rem_ext = CMP_W'(rem_prev);
         if (rem_ext >= trial) begin
            rem_in = owdm_pkg::NUM_W'(rem_ext - trial);
            quo_in = {quo_prev[owdm_pkg::QUO_W-2:0], 1'b1};
         end else begin
            rem_in = rem_prev;
            quo_in = {quo_prev[owdm_pkg::QUO_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= rem_in;
         den_ff[s] <= den_prev;
         quo_ff[s] <= quo_in;
      end
   end

   assign quo = quo_ff[owdm_pkg::QUO_W-1];
endmodule
`default_nettype wire

// ===== tb/sv/omni_wheel_drive_mixer_tb.sv =====
// testbench for the omni wheel drive mixer: random and directed commands with random gaps
// predicts the eight bridge duties per command and checks each transfer; depends on owdm_pkg
`timescale 1ns / 100ps
module omni_wheel_drive_mixer_tb;
   typedef struct {
      logic [1:0] op;
      logic [8:0] heading;
      logic [8:0] gyro;
   } command_type;

   typedef struct {
      logic [7:0] duty [8];
   } duties_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   wire busy;
   logic [1:0] req_operation = '0;
   logic [8:0] req_heading_angle = '0;
   logic [8:0] req_gyro_heading = '0;
   logic csr_write_enable = 0;
   logic [1:0] csr_index = '0;
   logic [8:0] csr_write_data = '0;
   wire rsp_valid;
   wire [7:0] rsp_duty [8];

   command_type pending_cmds [$];
   duties_type duty_expected [$];
   int mismatches = 0;
   int idle_cycles = 0;
   int gap = 0;

   // mixer settings mirrored by the testbench
   int speed_reg = 0;
   int corr_reg = 20;
   int db_low_reg = 10;
   int db_high_reg = 350;
   longint qsine [0:90];

   omni_wheel_drive_mixer i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_heading_angle(req_heading_angle),
      .req_gyro_heading(req_gyro_heading),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .rsp_valid(rsp_valid),
      .rsp_wheel0_pin_a_duty(rsp_duty[0]), .rsp_wheel0_pin_b_duty(rsp_duty[1]),
      .rsp_wheel1_pin_a_duty(rsp_duty[2]), .rsp_wheel1_pin_b_duty(rsp_duty[3]),
      .rsp_wheel2_pin_a_duty(rsp_duty[4]), .rsp_wheel2_pin_b_duty(rsp_duty[5]),
      .rsp_wheel3_pin_a_duty(rsp_duty[6]), .rsp_wheel3_pin_b_duty(rsp_duty[7])
   );

   always #6 clock = ~clock;

   function automatic longint q30_round(longint v);
      if (v >= 0) return (v + (longint'(1) << 29)) >>> 30;
      return -((-v + (longint'(1) << 29)) >>> 30);
   endfunction

   function automatic void fill_sines();
      longint c, s, nc, sp, r;
      c = longint'(1) << 30;
      s = 0;
      for (int d = 0; d <= 90; d++) begin
         sp = (s < 0) ? 0 : s;
         r = (sp + (longint'(1) << (29 - owdm_pkg::FRACTION_BITS)))
            >>> (30 - owdm_pkg::FRACTION_BITS);
         if (r > (longint'(1) << owdm_pkg::FRACTION_BITS))
            r = longint'(1) << owdm_pkg::FRACTION_BITS;
         qsine[d] = r;
         nc = q30_round(c * 1073578288 - s * 18739379);
         s = q30_round(s * 1073578288 + c * 18739379);
         c = nc;
      end
   endfunction

   function automatic longint sine_of(int x);
      int d;
      d = ((x % 360) + 360) % 360;
      if (d <= 90) return qsine[d];
      if (d <= 180) return qsine[180 - d];
      if (d <= 270) return -qsine[d - 180];
      return -qsine[360 - d];
   endfunction

   function automatic duties_type mix_wheels(command_type c);
      duties_type r;
      longint one, mx, add, p, mag, f [4];
      int a;
      int mounts [4] = '{40, 140, 225, 315};
      one = longint'(1) << owdm_pkg::FRACTION_BITS;
      mx = 0;
      add = 0;
      if (c.op == owdm_pkg::OP_BRAKE) begin
         foreach (r.duty[i]) r.duty[i] = 8'(owdm_pkg::DUTY_MAX);
         return r;
      end
      if (c.op != owdm_pkg::OP_RUN) begin
         foreach (r.duty[i]) r.duty[i] = 8'd0;
         return r;
      end
      a = 450 - int'(c.heading);
      if (a > 360) a -= 360;
      for (int w = 0; w < 4; w++) begin
         f[w] = -sine_of(a - mounts[w]);
         if (mx < f[w]) mx = f[w];
      end
      if (mx < one && mx > 0)
         for (int w = 0; w < 4; w++) f[w] = (f[w] * one) / mx;
      if (c.gyro >= db_low_reg && c.gyro < 180) add = -corr_reg;
      else if (c.gyro < db_high_reg && c.gyro >= 180) add = corr_reg;
      for (int w = 0; w < 4; w++) begin
         p = (speed_reg * f[w] + add * one) / one;
         mag = p < 0 ? -p : p;
         if (mag > owdm_pkg::DUTY_MAX) mag = owdm_pkg::DUTY_MAX;
         r.duty[2*w] = p < 0 ? 8'(mag) : (p == 0 ? 8'(owdm_pkg::DUTY_MAX) : 8'd0);
         r.duty[2*w+1] = p > 0 ? 8'(mag) : (p == 0 ? 8'(owdm_pkg::DUTY_MAX) : 8'd0);
      end
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
      end else if (start && busy) begin
         // hold until taken
      end else if (gap > 0) begin
         start <= 0;
         gap <= gap - 1;
      end else if (pending_cmds.size() > 0) begin
         command_type c;
         c = pending_cmds.pop_front();
         duty_expected.push_back(mix_wheels(c));
         start <= 1;
         req_operation <= c.op;
         req_heading_angle <= c.heading;
         req_gyro_heading <= c.gyro;
         if ($urandom_range(0, 3) == 0)
            gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      end else begin
         start <= 0;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (duty_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer at %0t", $realtime);
         end else begin
            duties_type e;
            e = duty_expected.pop_front();
            for (int i = 0; i < 8; i++)
               if (rsp_duty[i] !== e.duty[i]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("duty %0d: expected %0d, got %0d", i, e.duty[i], rsp_duty[i]);
               end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset || csr_write_enable || gap > 0
            || (pending_cmds.size() == 0 && duty_expected.size() == 0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic drain();
      while (pending_cmds.size() > 0 || duty_expected.size() > 0 || start)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, int value);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= 9'(value);
      @(posedge clock);
      csr_write_enable <= 0;
      case (idx)
         owdm_pkg::CSR_DRIVE_SPEED: speed_reg = value & 8'hff;
         owdm_pkg::CSR_CORRECTION_POWER: corr_reg = value & 8'hff;
         owdm_pkg::CSR_DEADBAND_LOW: db_low_reg = value & 9'h1ff;
         default: db_high_reg = value & 9'h1ff;
      endcase
   endtask

   task automatic add_cmd(logic [1:0] op, logic [8:0] h, logic [8:0] g);
      command_type c;
      c.op = op;
      c.heading = h;
      c.gyro = g;
      pending_cmds.push_back(c);
   endtask

   initial begin
      fill_sines();
      repeat (6) @(posedge clock);
      reset <= 0;
      // directed: reset settings first
      add_cmd(owdm_pkg::OP_RUN, 0, 0);
      add_cmd(owdm_pkg::OP_BRAKE, 9'h1ff, 9'h1ff);
      add_cmd(owdm_pkg::OP_COAST, 123, 200);
      add_cmd(2'd3, 45, 10);
      drain();
      write_reg(owdm_pkg::CSR_DRIVE_SPEED, 255);
      write_reg(owdm_pkg::CSR_CORRECTION_POWER, 255);
      write_reg(owdm_pkg::CSR_DEADBAND_LOW, 0);
      write_reg(owdm_pkg::CSR_DEADBAND_HIGH, 511);
      add_cmd(owdm_pkg::OP_RUN, 0, 0);
      add_cmd(owdm_pkg::OP_RUN, 90, 179);
      add_cmd(owdm_pkg::OP_RUN, 45, 180);
      add_cmd(owdm_pkg::OP_RUN, 359, 359);
      add_cmd(owdm_pkg::OP_RUN, 9'h1ff, 9'h1ff);
      add_cmd(owdm_pkg::OP_RUN, 400, 256);
      add_cmd(owdm_pkg::OP_RUN, 180, 9);
      add_cmd(owdm_pkg::OP_RUN, 270, 350);
      drain();
      for (int phase = 0; phase < 6; phase++) begin
         write_reg(owdm_pkg::CSR_DRIVE_SPEED, phase == 0 ? 0 : $urandom_range(0, 255));
         write_reg(owdm_pkg::CSR_CORRECTION_POWER, phase == 1 ? 0 : $urandom_range(0, 255));
         write_reg(owdm_pkg::CSR_DEADBAND_LOW, phase == 2 ? 511 : $urandom_range(0, 359));
         write_reg(owdm_pkg::CSR_DEADBAND_HIGH, phase == 2 ? 0 : $urandom_range(180, 359));
         for (int n = 0; n < 275; n++) begin
            logic [1:0] op;
            op = ($urandom_range(0, 9) < 7) ? owdm_pkg::OP_RUN : 2'($urandom_range(1, 3));
            add_cmd(op,
                    ($urandom_range(0, 19) == 0) ? 9'($urandom) : 9'($urandom_range(0, 359)),
                    ($urandom_range(0, 19) == 0) ? 9'($urandom) : 9'($urandom_range(0, 359)));
         end
         drain();
      end
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
